// ----- src/dlps_pkg.sv -----
// shared constants, register map and configuration struct of the pitch shifter
package dlps_pkg;

  localparam int unsigned MAX_DELAY   = 8192;
  localparam int unsigned ADDR_W      = $clog2(MAX_DELAY);
  localparam int unsigned DL_W        = ADDR_W + 1;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned PHASE_W     = 24;
  localparam int unsigned PER_W       = 20;
  localparam int unsigned PROD_W      = DL_W + PHASE_W;
  localparam int unsigned DIFF_W      = SAMPLE_W + 1;
  localparam int unsigned MAC_W       = DIFF_W + PHASE_W + 1;
  localparam int unsigned REM_CNT_W   = $clog2(ADDR_W + 1);
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;

  // register indexes, byte address 4*index
  localparam logic [1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [1:0] REG_PHASOR_PERIOD = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP    = 2'd2;
  localparam logic [1:0] REG_DIRECTION     = 2'd3;

  localparam logic [DL_W-1:0]    RST_DELAY_LENGTH  = DL_W'(4410);
  localparam logic [PER_W-1:0]   RST_PHASOR_PERIOD = PER_W'(44100);
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP    = PHASE_W'(380);

  localparam logic [DL_W-1:0] DL_MIN = DL_W'(2);
  localparam logic [DL_W-1:0] DL_MAX = DL_W'(MAX_DELAY);

  typedef struct packed {
    logic [DL_W-1:0]    dl;
    logic [PER_W-1:0]   period;
    logic [PHASE_W-1:0] step;
    logic               dir;
  } cfg_t;

endpackage

// ----- src/dlps_in_if.sv -----
// input sample channel
interface dlps_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dlps_pkg::SAMPLE_W-1:0]    sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ----- src/dlps_out_if.sv -----
// output sample channel
interface dlps_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dlps_pkg::SAMPLE_W-1:0]    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ----- src/dlps_regs.sv -----
// apb configuration registers with clamped delay length
module dlps_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dlps_pkg::PADDR_W-1:0]   paddr,
  input  logic [dlps_pkg::PDATA_W-1:0]   pwdata,
  output logic [dlps_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output dlps_pkg::cfg_t                 cfg_o
);

  logic [dlps_pkg::DL_W-1:0]    dl_q;
  logic [dlps_pkg::PER_W-1:0]   period_q;
  logic [dlps_pkg::PHASE_W-1:0] step_q;
  logic                         dir_q;
  logic                         wr_en;
  logic [1:0]                   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q     <= dlps_pkg::RST_DELAY_LENGTH;
      period_q <= dlps_pkg::RST_PHASOR_PERIOD;
      step_q   <= dlps_pkg::RST_PHASE_STEP;
      dir_q    <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        dlps_pkg::REG_DELAY_LENGTH:  dl_q     <= pwdata[dlps_pkg::DL_W-1:0];
        dlps_pkg::REG_PHASOR_PERIOD: period_q <= pwdata[dlps_pkg::PER_W-1:0];
        dlps_pkg::REG_PHASE_STEP:    step_q   <= pwdata[dlps_pkg::PHASE_W-1:0];
        dlps_pkg::REG_DIRECTION:     dir_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dlps_pkg::REG_DELAY_LENGTH:  prdata = dlps_pkg::PDATA_W'(dl_q);
      dlps_pkg::REG_PHASOR_PERIOD: prdata = dlps_pkg::PDATA_W'(period_q);
      dlps_pkg::REG_PHASE_STEP:    prdata = dlps_pkg::PDATA_W'(step_q);
      dlps_pkg::REG_DIRECTION:     prdata = dlps_pkg::PDATA_W'(dir_q);
      default:                     prdata = '0;
    endcase
  end

  // lengths outside the supported span act as the nearest limit
  always_comb begin
    if (dl_q < dlps_pkg::DL_MIN) begin
      cfg_o.dl = dlps_pkg::DL_MIN;
    end else if (dl_q > dlps_pkg::DL_MAX) begin
      cfg_o.dl = dlps_pkg::DL_MAX;
    end else begin
      cfg_o.dl = dl_q;
    end
    cfg_o.period = period_q;
    cfg_o.step   = step_q;
    cfg_o.dir    = dir_q;
  end

endmodule

// ----- src/dlps_rem.sv -----
// bit-serial remainder of the write pointer by the delay length
module dlps_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dlps_pkg::ADDR_W-1:0]   dividend_i,
  input  logic [dlps_pkg::DL_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [dlps_pkg::ADDR_W-1:0]   rem_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [dlps_pkg::REM_CNT_W-1:0]    cnt_q;
  logic [dlps_pkg::ADDR_W-1:0]       dvd_q;
  logic [dlps_pkg::DL_W-1:0]         rem_q;
  logic [dlps_pkg::DL_W-1:0]         trial;
  logic [dlps_pkg::DL_W-1:0]         rem_d;

  // remainder stays below the divisor, so the shifted value fits
  assign trial = {rem_q[dlps_pkg::DL_W-2:0], dvd_q[dlps_pkg::ADDR_W-1]};
  assign rem_d = (trial >= divisor_i) ? trial - divisor_i : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= dlps_pkg::REM_CNT_W'(dlps_pkg::ADDR_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[dlps_pkg::ADDR_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[dlps_pkg::ADDR_W-1:0];

endmodule

// ----- src/dlps_core.sv -----
// sequencer, delay store and interpolation datapath
module dlps_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dlps_pkg::cfg_t  cfg_i,
  dlps_in_if.sink         in_i,
  dlps_out_if.source      out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_RDA  = 3'd4;
  localparam logic [2:0] ST_RDB  = 3'd5;
  localparam logic [2:0] ST_PROD = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam int unsigned AW = dlps_pkg::ADDR_W;
  localparam int unsigned DW = dlps_pkg::DL_W;
  localparam int unsigned PW = dlps_pkg::PHASE_W;
  localparam int unsigned SW = dlps_pkg::SAMPLE_W;

  logic [2:0]                         state_q, state_d;
  logic [AW-1:0]                      wp_q;
  logic [dlps_pkg::PER_W-1:0]         pcnt_q;
  logic [PW-1:0]                      acc_q;
  logic [DW-1:0]                      fill_q;
  logic                               ov_q;
  logic signed [SW-1:0]               y_q;

  logic signed [SW-1:0]               x_q;
  logic [PW-1:0]                      ph_q;
  logic [AW-1:0]                      wpm_q;
  logic [dlps_pkg::PROD_W-1:0]        prod_q;
  logic [PW-1:0]                      frac_q;
  logic [AW-1:0]                      nxt_q;
  logic                               va_q, vb_q;
  logic signed [SW-1:0]               a_q;
  logic signed [dlps_pkg::DIFF_W-1:0] d_q;
  logic signed [dlps_pkg::MAC_W-1:0]  p_q;

  logic [SW-1:0]                      mem [dlps_pkg::MAX_DELAY];
  logic [SW-1:0]                      rdata_q;
  logic [AW-1:0]                      raddr;
  logic                               we;

  logic                               accept, wrap, out_free;
  logic                               rem_start, rem_done;
  logic [AW-1:0]                      rem_val;
  logic signed [PW+1:0]               ph_fall;
  logic [PW-1:0]                      ph_sel;
  logic [DW-1:0]                      hi;
  logic signed [DW:0]                 k, kw;
  logic [AW-1:0]                      rpi;
  logic [DW-1:0]                      nxt_w;
  logic signed [SW-1:0]               a_cur, b_cur;
  logic signed [dlps_pkg::MAC_W-1:0]  sum;
  logic signed [dlps_pkg::MAC_W-PW-1:0] y_w;
  logic signed [SW-1:0]               y_sat;
  logic [dlps_pkg::PER_W-1:0]         per_m1;

  assign accept    = (state_q == ST_IDLE) && in_i.valid;
  assign wrap      = {1'b0, wp_q} >= cfg_i.dl;
  assign rem_start = accept && wrap;
  assign out_free  = !ov_q || out_o.ready;
  assign we        = (state_q == ST_OUT) && out_free;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = ov_q;
  assign out_o.sample_out = y_q;

  dlps_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (wp_q),
    .divisor_i  (cfg_i.dl),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // read phase: the accumulator, or with direction set a falling ramp that mirrors it, clamped into [0, one)
  always_comb begin
    ph_fall = (PW+2)'(1) <<< PW;
    ph_fall = ph_fall - $signed({2'b00, cfg_i.step}) - $signed({2'b00, acc_q});
    if (!cfg_i.dir) begin
      ph_sel = acc_q;
    end else if (ph_fall < 0) begin
      ph_sel = '0;
    end else if (ph_fall[PW]) begin
      ph_sel = '1;
    end else begin
      ph_sel = ph_fall[PW-1:0];
    end
  end

  // integer part is floor of (wp - dl*phase), reduced modulo dl
  always_comb begin
    hi    = prod_q[dlps_pkg::PROD_W-1:PW];
    k     = $signed({2'b00, wpm_q}) - $signed({1'b0, hi})
            - $signed((DW+1)'(|prod_q[PW-1:0]));
    kw    = k[DW] ? k + $signed({1'b0, cfg_i.dl}) : k;
    rpi   = kw[AW-1:0];
    nxt_w = DW'(rpi) + 1'b1;
    if (nxt_w >= cfg_i.dl) begin
      nxt_w = '0;
    end
  end

  assign raddr = (state_q == ST_ADDR) ? rpi : nxt_q;

  // entries past the fill mark were never written and read as zero
  assign a_cur = va_q ? $signed(rdata_q) : '0;
  assign b_cur = vb_q ? $signed(rdata_q) : '0;

  always_comb begin
    sum   = ($signed(dlps_pkg::MAC_W'(a_q)) <<< PW) + p_q
            + $signed(dlps_pkg::MAC_W'(1) <<< (PW - 1));
    y_w   = sum[dlps_pkg::MAC_W-1:PW];
    if (y_w > $signed((dlps_pkg::MAC_W-PW)'({1'b0, {(SW-1){1'b1}}}))) begin
      y_sat = {1'b0, {(SW-1){1'b1}}};
    end else if (y_w < $signed({{(dlps_pkg::MAC_W-PW-SW+1){1'b1}}, {(SW-1){1'b0}}})) begin
      y_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_sat = y_w[SW-1:0];
    end
  end

  assign per_m1 = (cfg_i.period == '0) ? '0 : cfg_i.period - 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = wrap ? ST_DIV : ST_MUL;
      ST_DIV:  if (rem_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_RDA;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_PROD;
      ST_PROD: state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      pcnt_q  <= '0;
      acc_q   <= '0;
      fill_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= we || (ov_q && !out_o.ready);
      if (we) begin
        if ({1'b0, wp_q} >= fill_q) begin
          fill_q <= DW'(wp_q) + 1'b1;
        end
        wp_q <= ({1'b0, wp_q} >= cfg_i.dl - 1'b1) ? '0 : wp_q + 1'b1;
        if (pcnt_q >= per_m1) begin
          pcnt_q <= '0;
          acc_q  <= '0;
        end else begin
          pcnt_q <= pcnt_q + 1'b1;
          acc_q  <= acc_q + cfg_i.step;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= in_i.sample_in;
      ph_q  <= ph_sel;
      wpm_q <= wp_q;
    end
    if (state_q == ST_DIV && rem_done) begin
      wpm_q <= rem_val;
    end
    if (state_q == ST_MUL) begin
      prod_q <= cfg_i.dl * ph_q;
    end
    if (state_q == ST_ADDR) begin
      frac_q <= PW'(-prod_q[PW-1:0]);
      nxt_q  <= nxt_w[AW-1:0];
      va_q   <= DW'(rpi) < fill_q;
      vb_q   <= nxt_w < fill_q;
    end
    if (state_q == ST_RDA) begin
      a_q <= a_cur;
    end
    if (state_q == ST_RDB) begin
      d_q <= dlps_pkg::DIFF_W'(b_cur) - dlps_pkg::DIFF_W'(a_q);
    end
    if (state_q == ST_PROD) begin
      p_q <= dlps_pkg::MAC_W'(d_q * $signed({1'b0, frac_q}));
    end
    if (we) begin
      y_q <= y_sat;
    end
  end

  // delay store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= x_q;
    end
    rdata_q <= mem[raddr];
  end

endmodule

// ----- src/delay_line_pitch_shifter.sv -----
// top level of the delay-line pitch shifter
//
//  channel  dir  handshake              payload
//  in_i     in   valid/ready            sample_in  (s24, Q1.23)
//  out_o    out  valid/ready            sample_out (s24, Q1.23, saturated)
//  apb      in   psel/penable, pready=1 delay_length, phasor_period, phase_step, direction
//
// an item passes the states mul, addr, rda, rdb, prod and out on its way to the output register,
// a sequence set by the single read port of the delay store (two reads) and the two multiplies in turn
// the first item after the delay length is cut below the write pointer first passes through
// the bit-serial remainder unit
// no clearing pass after reset: a fill mark makes unwritten entries read as zero
// a new item is taken while the previous result waits; the result stage holds on stall
module delay_line_pitch_shifter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dlps_in_if.sink                        in_i,
  dlps_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dlps_pkg::PADDR_W-1:0]   paddr,
  input  logic [dlps_pkg::PDATA_W-1:0]   pwdata,
  output logic [dlps_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  dlps_pkg::cfg_t cfg;

  dlps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dlps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
